// ===== rtl/xcp_pkg.sv =====
// ----------------------------------------------------------------------------
// XCP command responder package
// Shared constants, command and error codes, configuration and state types.
// ----------------------------------------------------------------------------
package xcp_pkg;

    localparam int MAX_CTO       = 8;
    localparam int MAX_DTO       = 64;
    localparam int MEM_BYTES_DEF = 4096;

    localparam int CNT_W = $clog2(MAX_DTO);

    localparam logic [31:0] WIN_BASE_RST = 32'h2000_0000;
    localparam logic [12:0] WIN_SIZE_RST = 13'd4096;

    localparam logic [7:0] CMD_CONNECT        = 8'hFF;
    localparam logic [7:0] CMD_DISCONNECT     = 8'hFE;
    localparam logic [7:0] CMD_GET_STATUS     = 8'hFD;
    localparam logic [7:0] CMD_SYNCH          = 8'hFC;
    localparam logic [7:0] CMD_GET_COMM_MODE  = 8'hFB;
    localparam logic [7:0] CMD_GET_ID         = 8'hFA;
    localparam logic [7:0] CMD_SET_MTA        = 8'hF6;
    localparam logic [7:0] CMD_UPLOAD         = 8'hF5;
    localparam logic [7:0] CMD_SHORT_UPLOAD   = 8'hF4;
    localparam logic [7:0] CMD_DOWNLOAD       = 8'hF0;

    localparam logic [7:0] PID_RES = 8'hFF;
    localparam logic [7:0] PID_ERR = 8'hFE;

    localparam logic [7:0] ERR_CMD_RESYNC   = 8'h00;
    localparam logic [7:0] ERR_CMD_UNKNOWN  = 8'h20;
    localparam logic [7:0] ERR_OUT_OF_RANGE = 8'h22;

    localparam logic [7:0] RESOURCE_CAL   = 8'h01;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] PROTOCOL_VER   = 8'h01;
    localparam logic [7:0] TRANSPORT_VER  = 8'h01;
    localparam logic [7:0] ID_MODE_INLINE = 8'h01;
    localparam logic [7:0] COMM_DRV_VER   = 8'h01;

    typedef enum logic [1:0] {
        REG_WIN_BASE,
        REG_WIN_SIZE,
        REG_ID_STRING,
        REG_ID_LEN
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0] win_base;
        logic [12:0] win_size;
        logic [63:0] id_string;
        logic [3:0]  id_len;
    } t_cfg;

endpackage

// ===== rtl/xcp_command_responder.sv =====
// A command is decoded in ST_EXEC and its response leaves from ST_EMIT through the
// registered output stage, one response byte per cycle while the output is not stalled.
// A command holds the block until its whole response is sent, up to 64 bytes for a
// 63-byte upload, and a download also until its bytes are written. After reset the
// byte store (MEM_BYTES bytes, 4096 by default) is cleared before the first command
// is taken; configuration writes are accepted at all times.
// ----------------------------------------------------------------------------
// XCP command responder
// Answers XCP command packets byte by byte from a session state and byte store.
// ----------------------------------------------------------------------------
module xcp_command_responder #(
    parameter int MEM_BYTES = xcp_pkg::MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // command_code, packet_length, payload
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // response_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // session_connected
);

    import xcp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_base  <= WIN_BASE_RST;
            r_cfg.win_size  <= WIN_SIZE_RST;
            r_cfg.id_string <= 64'd0;
            r_cfg.id_len    <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WIN_BASE:  r_cfg.win_base  <= i_cfg_wdata[31:0];
                REG_WIN_SIZE:  r_cfg.win_size  <= i_cfg_wdata[12:0];
                REG_ID_STRING: r_cfg.id_string <= i_cfg_wdata;
                REG_ID_LEN:    r_cfg.id_len    <= i_cfg_wdata[3:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    xcp_engine #(
        .MEM_BYTES (MEM_BYTES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/xcp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module xcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/xcp_win_chk.sv =====
// ----------------------------------------------------------------------------
// XCP memory window check
// Validates an access of n bytes against the window and gives its store offset.
// ----------------------------------------------------------------------------
module xcp_win_chk #(
    parameter int MEM_BYTES = xcp_pkg::MEM_BYTES_DEF
) (
    input  logic [31:0]                  i_addr,
    input  logic [7:0]                   i_n,
    input  logic [31:0]                  i_base,
    input  logic [12:0]                  i_size,
    output logic                         o_ok,
    output logic [$clog2(MEM_BYTES)-1:0] o_offset
);

    localparam int          AW           = $clog2(MEM_BYTES);
    localparam logic [32:0] MEM_BYTES_33 = 33'(MEM_BYTES);

    logic [32:0] size_ext;
    logic [32:0] eff_size;
    logic [32:0] acc_end;
    logic [32:0] win_end;
    logic [31:0] diff;

    always_comb begin
        size_ext = {20'b0, i_size};
        eff_size = (size_ext > MEM_BYTES_33) ? MEM_BYTES_33 : size_ext;
        acc_end  = {1'b0, i_addr} + {25'b0, i_n};
        win_end  = {1'b0, i_base} + eff_size;
        diff     = i_addr - i_base;
        o_ok     = (i_n != 8'd0) && (i_addr >= i_base) && (acc_end <= win_end);
        o_offset = diff[AW-1:0];
    end

endmodule

// ===== rtl/xcp_engine.sv =====
// ----------------------------------------------------------------------------
// XCP command engine
// Decodes a command, updates session state and the byte store, and streams
// the response bytes through a registered output stage.
// ----------------------------------------------------------------------------
module xcp_engine #(
    parameter int MEM_BYTES = xcp_pkg::MEM_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xcp_pkg::t_cfg i_cfg,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // command_code, packet_length, payload
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,   // response_byte
    output logic          m_axis_tlast,
    output logic          m_axis_tuser    // session_connected
);

    import xcp_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    t_state         r_state, n_state;
    logic [7:0]     r_code, n_code;
    logic [3:0]     r_len, n_len;
    logic [55:0]    r_payload, n_payload;
    logic           r_connected, n_connected;
    logic [31:0]    r_mta, n_mta;
    logic [127:0]   r_hdr, n_hdr;
    logic [4:0]     r_hdr_cnt, n_hdr_cnt;
    logic [AW-1:0]  r_rd_addr, n_rd_addr;
    logic [CNT_W-1:0] r_rd_cnt, n_rd_cnt;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic           r_pend, n_pend;
    logic [AW-1:0]  r_wr_addr, n_wr_addr;
    logic [2:0]     r_wr_cnt, n_wr_cnt;
    logic [47:0]    r_wr_data, n_wr_data;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_data, n_out_data;
    logic           r_out_last, n_out_last;
    logic           r_out_user, n_out_user;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [7:0]     ram_rdata;

    logic [7:0]     cmd_n;
    logic [31:0]    cmd_addr;
    logic [3:0]     len_c;
    logic [3:0]     id_len_c;
    logic [31:0]    win_addr;
    logic           win_ok;
    logic [AW-1:0]  win_offset;
    logic           out_free;
    logic           hdr_load;
    logic           mem_load;
    logic           rd_issue;

    xcp_win_chk #(
        .MEM_BYTES (MEM_BYTES)
    ) u_win_chk (
        .i_addr   (win_addr),
        .i_n      (cmd_n),
        .i_base   (i_cfg.win_base),
        .i_size   (i_cfg.win_size),
        .o_ok     (win_ok),
        .o_offset (win_offset)
    );

    xcp_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_connected <= 1'b0;
            r_mta       <= 32'd0;
            r_hdr_cnt   <= 5'd0;
            r_rd_cnt    <= '0;
            r_out_cnt   <= '0;
            r_pend      <= 1'b0;
            r_wr_addr   <= '0;
            r_wr_cnt    <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_connected <= n_connected;
            r_mta       <= n_mta;
            r_hdr_cnt   <= n_hdr_cnt;
            r_rd_cnt    <= n_rd_cnt;
            r_out_cnt   <= n_out_cnt;
            r_pend      <= n_pend;
            r_wr_addr   <= n_wr_addr;
            r_wr_cnt    <= n_wr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_len      <= n_len;
        r_payload  <= n_payload;
        r_hdr      <= n_hdr;
        r_rd_addr  <= n_rd_addr;
        r_wr_data  <= n_wr_data;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
    end

    always_comb begin
        cmd_n    = r_payload[7:0];
        cmd_addr = r_payload[55:24];
        len_c    = (r_len > 4'(MAX_CTO)) ? 4'(MAX_CTO) : r_len;
        id_len_c = (i_cfg.id_len > 4'd8) ? 4'd8 : i_cfg.id_len;
        win_addr = (r_code == CMD_SHORT_UPLOAD) ? cmd_addr : r_mta;

        out_free = !r_out_valid || m_axis_tready;
        hdr_load = (r_state == ST_EMIT) && out_free && (r_hdr_cnt != 5'd0);
        mem_load = (r_state == ST_EMIT) && out_free && (r_hdr_cnt == 5'd0) && r_pend;
        rd_issue = (r_state == ST_EMIT) && (r_rd_cnt != '0) && (!r_pend || mem_load);

        n_state     = r_state;
        n_code      = r_code;
        n_len       = r_len;
        n_payload   = r_payload;
        n_connected = r_connected;
        n_mta       = r_mta;
        n_hdr       = r_hdr;
        n_hdr_cnt   = r_hdr_cnt;
        n_rd_addr   = r_rd_addr;
        n_rd_cnt    = r_rd_cnt;
        n_out_cnt   = r_out_cnt;
        n_pend      = r_pend;
        n_wr_addr   = r_wr_addr;
        n_wr_cnt    = r_wr_cnt;
        n_wr_data   = r_wr_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;

        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = r_wr_data[7:0];
        ram_re    = rd_issue;

        s_axis_tready = (r_state == ST_IDLE);

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = BYTE_ZERO;
                if (r_wr_addr == AW'(MEM_BYTES - 1)) begin
                    n_wr_addr = '0;
                    n_state   = ST_IDLE;
                end else begin
                    n_wr_addr = r_wr_addr + AW'(1);
                end
            end

            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_code    = s_axis_tdata[7:0];
                    n_len     = s_axis_tdata[11:8];
                    n_payload = s_axis_tdata[67:12];
                    if (s_axis_tdata[11:8] != 4'd0) begin
                        n_state = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                n_hdr          = '0;
                n_hdr[7:0]     = PID_ERR;
                n_hdr[15:8]    = ERR_CMD_UNKNOWN;
                n_hdr_cnt      = 5'd2;
                n_state        = ST_EMIT;
                unique case (r_code) inside
                    CMD_CONNECT: begin
                        n_connected  = 1'b1;
                        n_hdr[63:0]  = {TRANSPORT_VER, PROTOCOL_VER,
                                        8'(MAX_DTO >> 8), 8'(MAX_DTO & 255),
                                        8'(MAX_CTO), BYTE_ZERO, RESOURCE_CAL, PID_RES};
                        n_hdr_cnt    = 5'd8;
                    end
                    CMD_DISCONNECT: begin
                        n_connected = 1'b0;
                        n_hdr[7:0]  = PID_RES;
                        n_hdr_cnt   = 5'd1;
                    end
                    CMD_GET_STATUS: begin
                        n_hdr[63:0] = {56'b0, PID_RES};
                        n_hdr_cnt   = 5'd6;
                    end
                    CMD_SYNCH: begin
                        n_hdr[15:8] = ERR_CMD_RESYNC;
                    end
                    CMD_GET_COMM_MODE: begin
                        n_hdr[63:0] = {COMM_DRV_VER, 48'b0, PID_RES};
                        n_hdr_cnt   = 5'd8;
                    end
                    CMD_GET_ID: begin
                        n_hdr[63:0]   = {24'b0, 4'b0, id_len_c, BYTE_ZERO, BYTE_ZERO,
                                         ID_MODE_INLINE, PID_RES};
                        n_hdr[127:64] = i_cfg.id_string;
                        n_hdr_cnt     = 5'd8 + {1'b0, id_len_c};
                    end
                    CMD_SET_MTA: begin
                        n_mta      = cmd_addr;
                        n_hdr[7:0] = PID_RES;
                        n_hdr_cnt  = 5'd1;
                    end
                    CMD_UPLOAD, CMD_SHORT_UPLOAD: begin
                        if ((cmd_n > 8'(MAX_DTO - 1)) || !win_ok) begin
                            n_hdr[15:8] = ERR_OUT_OF_RANGE;
                        end else begin
                            n_hdr[7:0] = PID_RES;
                            n_hdr_cnt  = 5'd1;
                            n_rd_addr  = win_offset;
                            n_rd_cnt   = cmd_n[CNT_W-1:0];
                            n_out_cnt  = cmd_n[CNT_W-1:0];
                            n_pend     = 1'b0;
                            if (r_code == CMD_UPLOAD) begin
                                n_mta = r_mta + {24'b0, cmd_n};
                            end
                        end
                    end
                    CMD_DOWNLOAD: begin
                        if ((cmd_n == 8'd0) || ({5'b0, len_c} < ({1'b0, cmd_n} + 9'd2))
                                || !win_ok) begin
                            n_hdr[15:8] = ERR_OUT_OF_RANGE;
                        end else begin
                            n_hdr[7:0] = PID_RES;
                            n_hdr_cnt  = 5'd1;
                            n_wr_addr  = win_offset;
                            n_wr_cnt   = cmd_n[2:0];
                            n_wr_data  = r_payload[55:8];
                            n_mta      = r_mta + {24'b0, cmd_n};
                        end
                    end
                    default: begin
                        n_hdr[15:8] = ERR_CMD_UNKNOWN;
                    end
                endcase
            end

            ST_EMIT: begin
                if (r_wr_cnt != 3'd0) begin
                    ram_we    = 1'b1;
                    n_wr_addr = r_wr_addr + AW'(1);
                    n_wr_cnt  = r_wr_cnt - 3'd1;
                    n_wr_data = {8'b0, r_wr_data[47:8]};
                end
                if (rd_issue) begin
                    n_rd_addr = r_rd_addr + AW'(1);
                    n_rd_cnt  = r_rd_cnt - CNT_W'(1);
                end
                if (hdr_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_hdr[7:0];
                    n_out_last  = (r_hdr_cnt == 5'd1) && (r_out_cnt == '0);
                    n_out_user  = r_connected;
                    n_hdr       = {8'b0, r_hdr[127:8]};
                    n_hdr_cnt   = r_hdr_cnt - 5'd1;
                end else if (mem_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = ram_rdata;
                    n_out_last  = (r_out_cnt == CNT_W'(1));
                    n_out_user  = r_connected;
                    n_out_cnt   = r_out_cnt - CNT_W'(1);
                end
                n_pend = rd_issue || (r_pend && !mem_load);
                if ((r_hdr_cnt == 5'd0) && (r_out_cnt == '0) && (r_wr_cnt == 3'd0)) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XCP command responder testbench
// Streams directed and random command packets into the responder while the
// window and identification registers change between phases. A behavioral
// copy of the session state, transfer address and byte store predicts every
// response byte, and each byte leaving the block is checked against it.
// ----------------------------------------------------------------------------
module testbench;
    import xcp_pkg::*;

    localparam int MEM_DEPTH   = MEM_BYTES_DEF;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int STALL_LIMIT = 40000;
    localparam logic [7:0] RESERVED_CODES [6] = '{8'hF9, 8'hF8, 8'hF7, 8'hF3, 8'hF2, 8'hF1};

    typedef struct packed {
        logic [7:0]  code;
        logic [3:0]  len;
        logic [55:0] payload;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       conn;
    } t_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // command_code, packet_length, payload
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // response_byte
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // session_connected

    xcp_command_responder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cmd        cmd_backlog [$];
    t_rsp        bytes_due [$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    logic        cmd_taken = 1'b0;
    logic        calm = 1'b0;

    // Shadow of the block's registers and session state.
    logic [31:0] cfg_base;
    logic [12:0] cfg_size;
    logic [63:0] cfg_id;
    logic [3:0]  cfg_id_len;
    logic        link_up;
    logic [31:0] mta;
    logic [7:0]  target_mem [MEM_DEPTH];

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic bit window_ok(logic [31:0] addr, int unsigned n);
        logic [32:0] limit;
        logic [32:0] top;
        logic [12:0] eff;
        eff = (cfg_size > MEM_DEPTH) ? 13'(MEM_DEPTH) : cfg_size;
        limit = {1'b0, cfg_base} + 33'(eff);
        top = {1'b0, addr} + 33'(n);
        return (n > 0) && (addr >= cfg_base) && (top <= limit);
    endfunction

    task automatic predict_response(logic [7:0] code, logic [3:0] len_in, logic [55:0] pl);
        logic [7:0]  bytes [$];
        logic [3:0]  len;
        logic [7:0]  n;
        logic [31:0] addr;
        logic [31:0] off;
        logic [3:0]  idl;
        t_rsp        r;
        if (len_in == 0)
            return;
        len = (len_in > MAX_CTO) ? 4'(MAX_CTO) : len_in;
        n = pl[7:0];
        addr = pl[55:24];
        case (code)
            CMD_CONNECT: begin
                link_up = 1'b1;
                bytes.push_back(PID_RES);
                bytes.push_back(RESOURCE_CAL);
                bytes.push_back(BYTE_ZERO);
                bytes.push_back(8'(MAX_CTO));
                bytes.push_back(8'(MAX_DTO));
                bytes.push_back(8'(MAX_DTO >> 8));
                bytes.push_back(PROTOCOL_VER);
                bytes.push_back(TRANSPORT_VER);
            end
            CMD_DISCONNECT: begin
                link_up = 1'b0;
                bytes.push_back(PID_RES);
            end
            CMD_GET_STATUS: begin
                bytes.push_back(PID_RES);
                repeat (5) bytes.push_back(BYTE_ZERO);
            end
            CMD_SYNCH: begin
                bytes.push_back(PID_ERR);
                bytes.push_back(ERR_CMD_RESYNC);
            end
            CMD_GET_COMM_MODE: begin
                bytes.push_back(PID_RES);
                repeat (6) bytes.push_back(BYTE_ZERO);
                bytes.push_back(COMM_DRV_VER);
            end
            CMD_GET_ID: begin
                idl = (cfg_id_len > 8) ? 4'd8 : cfg_id_len;
                bytes.push_back(PID_RES);
                bytes.push_back(ID_MODE_INLINE);
                bytes.push_back(BYTE_ZERO);
                bytes.push_back(BYTE_ZERO);
                bytes.push_back(8'(idl));
                repeat (3) bytes.push_back(BYTE_ZERO);
                for (int i = 0; i < idl; i++)
                    bytes.push_back(cfg_id[8*i +: 8]);
            end
            CMD_SET_MTA: begin
                mta = addr;
                bytes.push_back(PID_RES);
            end
            CMD_UPLOAD, CMD_SHORT_UPLOAD: begin
                if (code == CMD_UPLOAD)
                    addr = mta;
                if (int'(n) > MAX_DTO - 1 || !window_ok(addr, n)) begin
                    bytes.push_back(PID_ERR);
                    bytes.push_back(ERR_OUT_OF_RANGE);
                end else begin
                    off = addr - cfg_base;
                    bytes.push_back(PID_RES);
                    for (int i = 0; i < n; i++)
                        bytes.push_back(target_mem[MEM_AW'(off + i)]);
                    if (code == CMD_UPLOAD)
                        mta = mta + {24'd0, n};
                end
            end
            CMD_DOWNLOAD: begin
                if (n == 0 || int'(len) < int'(n) + 2 || !window_ok(mta, n)) begin
                    bytes.push_back(PID_ERR);
                    bytes.push_back(ERR_OUT_OF_RANGE);
                end else begin
                    off = mta - cfg_base;
                    for (int i = 0; i < n && i < 6; i++)
                        target_mem[MEM_AW'(off + i)] = pl[8*(i+1) +: 8];
                    mta = mta + {24'd0, n};
                    bytes.push_back(PID_RES);
                end
            end
            default: begin
                bytes.push_back(PID_ERR);
                bytes.push_back(ERR_CMD_UNKNOWN);
            end
        endcase
        foreach (bytes[k]) begin
            r.data = bytes[k];
            r.last = (k == bytes.size() - 1);
            r.conn = link_up;
            bytes_due.push_back(r);
        end
    endtask

    // Command side: a new packet is offered once the previous one was taken.
    always @(negedge i_clk) begin : cmd_driver
        t_cmd c;
        if (!s_axis_tvalid || cmd_taken) begin
            if (i_rst_n && cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
                c = cmd_backlog.pop_front();
                s_axis_tdata <= {4'b0, c.payload, c.len, c.code};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                end else begin
                    want = bytes_due.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch($sformatf("byte %02h, expected %02h",
                                                  m_axis_tdata, want.data));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_axis_tlast, want.last));
                    if (m_axis_tuser !== want.conn)
                        report_mismatch($sformatf("connected %b, expected %b",
                                                  m_axis_tuser, want.conn));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_response(s_axis_tdata[7:0], s_axis_tdata[11:8], s_axis_tdata[67:12]);
        end
        cmd_taken <= s_axis_tvalid && s_axis_tready;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [55:0] rand56();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[55:0];
    endfunction

    function automatic logic [7:0] pick_size();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 85)
            return 8'($urandom_range(1, 8));
        else if (p < 97)
            return 8'($urandom_range(9, MAX_DTO - 1));
        else
            return 8'($urandom_range(MAX_DTO, 255));
    endfunction

    task automatic push_cmd(logic [7:0] code, logic [3:0] len, logic [55:0] pl);
        t_cmd c;
        c.code = code;
        c.len = len;
        c.payload = pl;
        cmd_backlog.push_back(c);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_WIN_BASE:  cfg_base = val[31:0];
            REG_WIN_SIZE:  cfg_size = val[12:0];
            REG_ID_STRING: cfg_id = val;
            REG_ID_LEN:    cfg_id_len = val[3:0];
        endcase
    endtask

    task automatic set_window(logic [31:0] base, logic [12:0] size, logic [63:0] id,
                              logic [3:0] id_len);
        write_reg(REG_WIN_BASE, {32'd0, base});
        write_reg(REG_WIN_SIZE, {51'd0, size});
        write_reg(REG_ID_STRING, id);
        write_reg(REG_ID_LEN, {60'd0, id_len});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (cmd_backlog.size() != 0 || s_axis_tvalid || bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] addr_in_window();
        return cfg_base + $urandom_range(0, cfg_size - 1);
    endfunction

    // Mostly address-then-access sequences, the rest single and malformed packets.
    task automatic queue_random(int unsigned count);
        int unsigned made;
        int unsigned steps;
        logic [7:0]  n;
        logic [55:0] pl;
        made = 0;
        while (made < count) begin
            pl = rand56();
            if ($urandom_range(0, 99) < 60) begin
                pl[55:24] = addr_in_window();
                push_cmd(CMD_SET_MTA, 4'($urandom_range(1, 8)), pl);
                made++;
                steps = $urandom_range(1, 4);
                for (int k = 0; k < steps; k++) begin
                    pl = rand56();
                    case ($urandom_range(0, 2))
                        0: begin
                            n = 8'($urandom_range(1, 6));
                            pl[7:0] = n;
                            push_cmd(CMD_DOWNLOAD, 4'($urandom_range(n + 2, 8)), pl);
                        end
                        1: begin
                            pl[7:0] = pick_size();
                            push_cmd(CMD_UPLOAD, 4'($urandom_range(1, 8)), pl);
                        end
                        default: begin
                            pl[7:0] = pick_size();
                            pl[55:24] = addr_in_window();
                            push_cmd(CMD_SHORT_UPLOAD, 4'($urandom_range(1, 8)), pl);
                        end
                    endcase
                    made++;
                end
            end else begin
                case ($urandom_range(0, 10))
                    0: push_cmd(CMD_CONNECT, 4'($urandom_range(1, 8)), pl);
                    1: push_cmd(CMD_DISCONNECT, 4'($urandom_range(1, 8)), pl);
                    2: push_cmd(CMD_GET_STATUS, 4'($urandom_range(1, 8)), pl);
                    3: push_cmd(CMD_SYNCH, 4'($urandom_range(1, 8)), pl);
                    4: push_cmd(CMD_GET_COMM_MODE, 4'($urandom_range(1, 8)), pl);
                    5: push_cmd(CMD_GET_ID, 4'($urandom_range(1, 8)), pl);
                    6: push_cmd(8'($urandom_range(0, 255)), 4'($urandom_range(1, 8)), pl);
                    7: push_cmd(CMD_SHORT_UPLOAD, 4'($urandom_range(1, 8)), pl);
                    8: push_cmd(CMD_UPLOAD, 4'($urandom_range(1, 8)), pl);
                    9: push_cmd(CMD_DOWNLOAD, 4'($urandom_range(1, 8)), pl);
                    default: begin
                        push_cmd(8'($urandom_range(0, 255)), 4'd0, pl);
                        made--;
                    end
                endcase
                made++;
            end
        end
    endtask

    initial begin
        logic [55:0] pl;
        cfg_base = WIN_BASE_RST;
        cfg_size = WIN_SIZE_RST;
        cfg_id = '0;
        cfg_id_len = '0;
        link_up = 1'b0;
        mta = '0;
        foreach (target_mem[i])
            target_mem[i] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_window(WIN_BASE_RST, WIN_SIZE_RST, {$urandom, $urandom}, 4'd8);
        push_cmd(CMD_CONNECT, 4'd0, rand56());
        push_cmd(CMD_CONNECT, 4'd1, 56'd0);
        push_cmd(CMD_GET_STATUS, 4'd8, {56{1'b1}});
        push_cmd(CMD_SYNCH, 4'd1, rand56());
        push_cmd(CMD_GET_COMM_MODE, 4'd1, rand56());
        push_cmd(CMD_GET_ID, 4'd1, rand56());
        push_cmd(8'h00, 4'd1, rand56());
        foreach (RESERVED_CODES[i])
            push_cmd(RESERVED_CODES[i], 4'd2, rand56());
        push_cmd(CMD_SET_MTA, 4'd8, {WIN_BASE_RST, 24'd0});
        pl = rand56();
        pl[7:0] = 8'd6;
        push_cmd(CMD_DOWNLOAD, 4'd8, pl);
        pl = rand56();
        pl[7:0] = 8'd3;
        push_cmd(CMD_DOWNLOAD, 4'd4, pl);
        pl = rand56();
        pl[7:0] = 8'd0;
        push_cmd(CMD_DOWNLOAD, 4'd8, pl);
        push_cmd(CMD_SHORT_UPLOAD, 4'd8, {WIN_BASE_RST, 16'd0, 8'd6});
        push_cmd(CMD_UPLOAD, 4'd2, {48'd0, 8'(MAX_DTO)});
        push_cmd(CMD_SET_MTA, 4'd8, {WIN_BASE_RST, 24'd0});
        push_cmd(CMD_UPLOAD, 4'd2, {48'd0, 8'(MAX_DTO - 1)});
        push_cmd(CMD_SHORT_UPLOAD, 4'd8, {WIN_BASE_RST + 32'd4095, 16'd0, 8'd1});
        push_cmd(CMD_SHORT_UPLOAD, 4'd8, {WIN_BASE_RST + 32'd4095, 16'd0, 8'd2});
        push_cmd(CMD_SHORT_UPLOAD, 4'd8, {WIN_BASE_RST - 32'd1, 16'd0, 8'd1});
        push_cmd(CMD_DISCONNECT, 4'd1, rand56());
        wait_quiet();

        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: set_window(32'hFFFF_F000, 13'd4096, {64{1'b1}}, 4'd0);
                2: set_window(32'h0000_0000, 13'd1, {$urandom, $urandom}, 4'd8);
                3: set_window($urandom, 13'd16, {$urandom, $urandom}, 4'($urandom_range(0, 8)));
                4: set_window(WIN_BASE_RST, 13'($urandom_range(1, 4096)), 64'd0,
                              4'($urandom_range(0, 8)));
                5: set_window($urandom, 13'($urandom_range(1, 4096)), {$urandom, $urandom},
                              4'($urandom_range(0, 8)));
                default: set_window($urandom, 13'd4096, {$urandom, $urandom}, 4'd8);
            endcase
            calm = (ph == 3);
            if (ph == 1) begin
                // A window ending at the top of the address space: the sum needs the
                // carry bit, and the transfer address wraps to zero afterwards.
                push_cmd(CMD_SET_MTA, 4'd8, {32'hFFFF_FFC1, 24'd0});
                push_cmd(CMD_UPLOAD, 4'd2, {48'd0, 8'(MAX_DTO - 1)});
                push_cmd(CMD_UPLOAD, 4'd2, {48'd0, 8'd1});
            end
            if (ph == 4) begin
                queue_random(30);
                wait_quiet();
                queue_random(32);
            end else begin
                queue_random(62);
            end
            wait_quiet();
        end
        calm = 1'b0;

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
